FILE: rtl/vm_alu_with_nz_flags_unit_macros.svh
// ----------------------------------------------------------------------------
// vm_alu_with_nz_flags_unit_macros.svh
// Assertion shorthands used by the checker of the execute unit.
// ----------------------------------------------------------------------------
`ifndef VM_ALU_WITH_NZ_FLAGS_UNIT_MACROS_SVH
`define VM_ALU_WITH_NZ_FLAGS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VMALU_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VMALU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vmalu_pkg.sv
// ----------------------------------------------------------------------------
// vmalu_pkg
// Shared widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package vmalu_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 5;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned SHAMT_W   = $clog2(DATA_W);
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DATA_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_MOV  = 5'd0,
    CMD_ADD  = 5'd1,
    CMD_SUB  = 5'd2,
    CMD_MUL  = 5'd3,
    CMD_DIV  = 5'd4,
    CMD_CMP  = 5'd5,
    CMD_SHL  = 5'd6,
    CMD_SHR  = 5'd7,
    CMD_SAR  = 5'd8,
    CMD_AND  = 5'd9,
    CMD_OR   = 5'd10,
    CMD_XOR  = 5'd11,
    CMD_LDL  = 5'd12,
    CMD_LDH  = 5'd13,
    CMD_NOT  = 5'd14,
    CMD_JMP  = 5'd15,
    CMD_JZ   = 5'd16,
    CMD_JNZ  = 5'd17,
    CMD_JN   = 5'd18,
    CMD_JNN  = 5'd19,
    CMD_JP   = 5'd20,
    CMD_JNP  = 5'd21,
    CMD_SWAP = 5'd22
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_out;    // capture single-cycle result into output register
    logic div_start;   // load divider with operand magnitudes
    logic div_step;    // one restoring-divide iteration
    logic div_finish;  // capture signed quotient/remainder into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;      // incoming transaction needs the iterative divider
    logic div_done;    // all divide iterations complete
  } dp_stat_t;

endpackage

FILE: rtl/vmalu_if.sv
// ----------------------------------------------------------------------------
// vmalu_if
// Valid/ready channels for operation requests and execute results.
// ----------------------------------------------------------------------------
interface vmalu_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [vmalu_pkg::CMD_W-1:0]   cmd;
  logic signed [vmalu_pkg::DATA_W-1:0]  operand_a;
  logic signed [vmalu_pkg::DATA_W-1:0]  operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface vmalu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vmalu_pkg::DATA_W-1:0]  result;
  logic signed [vmalu_pkg::DATA_W-1:0]  second_value;
  logic                                 writes_result;
  logic                                 branch_taken;
  logic                                 negative_flag;
  logic                                 zero_flag;
  logic                                 div_error;

  modport source (output valid, result, second_value, writes_result, branch_taken,
                  negative_flag, zero_flag, div_error, input ready);
  modport sink   (input valid, result, second_value, writes_result, branch_taken,
                  negative_flag, zero_flag, div_error, output ready);
endinterface

FILE: rtl/vmalu_ctrl.sv
// ----------------------------------------------------------------------------
// vmalu_ctrl
// Sequencer: accepts transactions, runs the divider, manages the output slot.
// ----------------------------------------------------------------------------
module vmalu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  vmalu_pkg::dp_stat_t stat,
  output vmalu_pkg::dp_cmd_t  ctl
);

  vmalu_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_space;
  logic              in_fire;

  // output slot is free now or drains at this edge
  assign out_space = !out_valid_r || out_ready;
  assign in_ready  = (state_r == vmalu_pkg::ST_IDLE) && out_space;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vmalu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vmalu_pkg::ST_IDLE: begin
        if (in_fire && stat.is_div) state_nxt = vmalu_pkg::ST_DIV;
      end
      vmalu_pkg::ST_DIV: begin
        if (stat.div_done && out_space) state_nxt = vmalu_pkg::ST_IDLE;
      end
      default: state_nxt = vmalu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      vmalu_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (stat.is_div) ctl.div_start = 1'b1;
          else             ctl.load_out  = 1'b1;
        end
      end
      vmalu_pkg::ST_DIV: begin
        if (!stat.div_done) ctl.div_step   = 1'b1;
        else if (out_space) ctl.div_finish = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_comb begin
    if (ctl.load_out || ctl.div_finish) out_valid_nxt = 1'b1;
    else if (out_ready)                 out_valid_nxt = 1'b0;
    else                                out_valid_nxt = out_valid_r;
  end

endmodule

FILE: rtl/vmalu_dp.sv
// ----------------------------------------------------------------------------
// vmalu_dp
// Datapath: single-cycle ALU, radix-2 restoring divider, N/Z flags, output regs.
// ----------------------------------------------------------------------------
module vmalu_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic        [vmalu_pkg::CMD_W-1:0]  cmd,
  input  logic signed [vmalu_pkg::DATA_W-1:0] operand_a,
  input  logic signed [vmalu_pkg::DATA_W-1:0] operand_b,
  input  vmalu_pkg::dp_cmd_t                  ctl,
  output vmalu_pkg::dp_stat_t                 stat,
  output logic signed [vmalu_pkg::DATA_W-1:0] result,
  output logic signed [vmalu_pkg::DATA_W-1:0] second_value,
  output logic                                writes_result,
  output logic                                branch_taken,
  output logic                                negative_flag,
  output logic                                zero_flag,
  output logic                                div_error
);

  localparam int unsigned W  = vmalu_pkg::DATA_W;
  localparam int unsigned SW = vmalu_pkg::SHAMT_W;
  localparam int unsigned HW = vmalu_pkg::HALF_W;

  logic [W-1:0]        a_u, b_u;
  logic signed [W-1:0] sar_v;
  logic [SW-1:0]       shamt;
  logic                shift_ok;
  logic                b_zero;

  logic [W-1:0] alu_res, alu_sec, flag_val;
  logic         alu_wr, alu_br, alu_derr, alu_upd, take;

  // divider state
  logic [W-1:0]                    rem_r, quo_r, dvs_r;
  logic [vmalu_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                            q_neg_r, r_neg_r;
  logic [W:0]                      rem_sh, trial;
  logic [W-1:0]                    q_fin, r_fin;

  // output registers and flags
  logic [W-1:0] res_r, sec_r;
  logic         wr_r, br_r, derr_r;
  logic         n_r, z_r;

  assign a_u      = operand_a;
  assign b_u      = operand_b;
  assign shamt    = b_u[SW-1:0];
  assign shift_ok = (b_u[W-1:SW] == '0);
  assign sar_v    = operand_a >>> shamt;
  assign b_zero   = (b_u == '0);

  assign stat.is_div   = (cmd == vmalu_pkg::CMD_DIV) && !b_zero;
  assign stat.div_done = (cnt_r == vmalu_pkg::DIV_STEPS);

  always_comb begin
    alu_res  = '0;
    alu_sec  = '0;
    alu_wr   = 1'b0;
    alu_br   = 1'b0;
    alu_derr = 1'b0;
    alu_upd  = 1'b0;
    take     = 1'b0;
    flag_val = '0;
    unique case (cmd)
      vmalu_pkg::CMD_MOV:  begin alu_res = b_u;       alu_wr = 1'b1; end
      vmalu_pkg::CMD_ADD:  begin alu_res = a_u + b_u; alu_wr = 1'b1; alu_upd = 1'b1; end
      vmalu_pkg::CMD_SUB:  begin alu_res = a_u - b_u; alu_wr = 1'b1; alu_upd = 1'b1; end
      vmalu_pkg::CMD_MUL:  begin alu_res = a_u * b_u; alu_wr = 1'b1; alu_upd = 1'b1; end
      // nonzero divisor goes through the divider; only the error case ends here
      vmalu_pkg::CMD_DIV:  alu_derr = b_zero;
      vmalu_pkg::CMD_CMP:  begin flag_val = a_u - b_u; alu_upd = 1'b1; end
      vmalu_pkg::CMD_SHL: begin
        alu_res = shift_ok ? (a_u << shamt) : '0;
        alu_wr  = 1'b1; alu_upd = 1'b1;
      end
      vmalu_pkg::CMD_SHR: begin
        alu_res = shift_ok ? (a_u >> shamt) : '0;
        alu_wr  = 1'b1; alu_upd = 1'b1;
      end
      vmalu_pkg::CMD_SAR: begin
        alu_res = shift_ok ? sar_v : {W{a_u[W-1]}};
        alu_wr  = 1'b1; alu_upd = 1'b1;
      end
      vmalu_pkg::CMD_AND:  begin alu_res = a_u & b_u; alu_wr = 1'b1; alu_upd = 1'b1; end
      vmalu_pkg::CMD_OR:   begin alu_res = a_u | b_u; alu_wr = 1'b1; alu_upd = 1'b1; end
      vmalu_pkg::CMD_XOR:  begin alu_res = a_u ^ b_u; alu_wr = 1'b1; alu_upd = 1'b1; end
      vmalu_pkg::CMD_LDL:  begin alu_res = {a_u[W-1:HW], b_u[HW-1:0]}; alu_wr = 1'b1; end
      vmalu_pkg::CMD_LDH:  begin alu_res = {b_u[HW-1:0], a_u[HW-1:0]}; alu_wr = 1'b1; end
      vmalu_pkg::CMD_NOT:  begin alu_res = ~a_u; alu_wr = 1'b1; alu_upd = 1'b1; end
      vmalu_pkg::CMD_JMP:  take = 1'b1;
      vmalu_pkg::CMD_JZ:   take = z_r;
      vmalu_pkg::CMD_JNZ:  take = !z_r;
      vmalu_pkg::CMD_JN:   take = n_r;
      vmalu_pkg::CMD_JNN:  take = !n_r;
      vmalu_pkg::CMD_JP:   take = !z_r && !n_r;
      vmalu_pkg::CMD_JNP:  take = z_r || n_r;
      vmalu_pkg::CMD_SWAP: begin alu_res = b_u; alu_sec = a_u; alu_wr = 1'b1; end
      default: ;
    endcase
    if (take) begin
      alu_br  = 1'b1;
      alu_res = a_u;
    end
    if (cmd != vmalu_pkg::CMD_CMP) flag_val = alu_res;
  end

  // restoring divide step on magnitudes
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign q_fin  = q_neg_r ? (~quo_r + 1'b1) : quo_r;
  assign r_fin  = r_neg_r ? (~rem_r + 1'b1) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.div_start) begin
      cnt_r <= '0;
    end else if (ctl.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      rem_r   <= '0;
      quo_r   <= a_u[W-1] ? (~a_u + 1'b1) : a_u;
      dvs_r   <= b_u[W-1] ? (~b_u + 1'b1) : b_u;
      q_neg_r <= a_u[W-1] ^ b_u[W-1];
      r_neg_r <= a_u[W-1];
    end else if (ctl.div_step) begin
      if (!trial[W]) begin
        rem_r <= trial[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= 1'b0;
      z_r <= 1'b0;
    end else if (ctl.load_out && alu_upd) begin
      n_r <= flag_val[W-1];
      z_r <= (flag_val == '0);
    end else if (ctl.div_finish) begin
      n_r <= q_fin[W-1];
      z_r <= (q_fin == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      res_r  <= alu_res;
      sec_r  <= alu_sec;
      wr_r   <= alu_wr;
      br_r   <= alu_br;
      derr_r <= alu_derr;
    end else if (ctl.div_finish) begin
      res_r  <= q_fin;
      sec_r  <= r_fin;
      wr_r   <= 1'b1;
      br_r   <= 1'b0;
      derr_r <= 1'b0;
    end
  end

  assign result        = res_r;
  assign second_value  = sec_r;
  assign writes_result = wr_r;
  assign branch_taken  = br_r;
  assign negative_flag = n_r;
  assign zero_flag     = z_r;
  assign div_error     = derr_r;

endmodule

FILE: rtl/vm_alu_with_nz_flags_unit.sv
// ----------------------------------------------------------------------------
// vm_alu_with_nz_flags_unit
// Execute unit of a small 32-bit VM with N and Z condition flags.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one operation (cmd, operand_a, operand_b) per transaction;
//   out_ch returns exactly one result transaction for each, in order.
//   Both channels are valid/ready; a transaction moves when both are high.
// Throughput:
//   Every operation except a DIV with nonzero divisor has its result
//   registered at acceptance, valid from the next cycle; a new operation can
//   be taken every cycle as long as the result side keeps up.
//   DIV runs a radix-2 restoring divider, one quotient bit per cycle, and
//   registers the result once all 32 iterations are done and the output
//   register is free; no new operation is taken meanwhile.
// Flags:
//   N and Z update when a flag-setting result or compare is registered, so a
//   jump sees the flags left by the last such transaction before it.
// Reset:
//   Synchronous, active low. Clears the flags, the sequencer and the output
//   valid; any operation in flight is dropped.
// Stall:
//   The result waits in the output register while out_ch.ready is low; a
//   new operation is accepted only once that register is free or draining.
// ----------------------------------------------------------------------------
module vm_alu_with_nz_flags_unit (
  input  logic         clk,
  input  logic         rst_n,
  vmalu_in_if.sink     in_ch,
  vmalu_out_if.source  out_ch
);

  vmalu_pkg::dp_cmd_t  ctl;
  vmalu_pkg::dp_stat_t stat;

  vmalu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  vmalu_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (in_ch.cmd),
    .operand_a     (in_ch.operand_a),
    .operand_b     (in_ch.operand_b),
    .ctl           (ctl),
    .stat          (stat),
    .result        (out_ch.result),
    .second_value  (out_ch.second_value),
    .writes_result (out_ch.writes_result),
    .branch_taken  (out_ch.branch_taken),
    .negative_flag (out_ch.negative_flag),
    .zero_flag     (out_ch.zero_flag),
    .div_error     (out_ch.div_error)
  );

endmodule

FILE: rtl/vmalu_checker.sv
// ----------------------------------------------------------------------------
// vmalu_checker
// Port-level checks on the execute unit's result channel.
// ----------------------------------------------------------------------------
`include "vm_alu_with_nz_flags_unit_macros.svh"

module vmalu_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [vmalu_pkg::DATA_W-1:0] out_result,
  input logic signed [vmalu_pkg::DATA_W-1:0] out_second_value,
  input logic                                out_writes_result,
  input logic                                out_branch_taken,
  input logic                                out_div_error
);

  `VMALU_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result transaction dropped while stalled")
  `VMALU_ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_valid && !out_ready, $stable(out_result) && $stable(out_second_value), "result payload changed while stalled")
  `VMALU_ASSERT_IMPL(a_div_err_quiet, clk, rst_n, out_valid && out_div_error, !out_writes_result && !out_branch_taken && out_result == '0 && out_second_value == '0, "divide error with live result fields")
  `VMALU_ASSERT_IMPL(a_branch_no_wb, clk, rst_n, out_valid && out_branch_taken, !out_writes_result && !out_div_error && out_second_value == '0, "taken branch also writes back")

endmodule

bind vm_alu_with_nz_flags_unit vmalu_checker u_vmalu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_result        (out_ch.result),
  .out_second_value  (out_ch.second_value),
  .out_writes_result (out_ch.writes_result),
  .out_branch_taken  (out_ch.branch_taken),
  .out_div_error     (out_ch.div_error)
);

FILE: dv/vm_alu_with_nz_flags_unit_tb.sv
// ----------------------------------------------------------------------------
// vm_alu_with_nz_flags_unit_tb
// Self-checking bench for the VM execute unit. A software copy of the ALU and
// its N/Z flags predicts every result transaction. Directed cases cover each
// operation and the corner cases. Random traffic follows, partly as
// compare/jump pairs. Both channels idle at random, and one long result stall
// backs the unit up.
// ----------------------------------------------------------------------------
module vm_alu_with_nz_flags_unit_tb;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned IDLE_PCT      = 6;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned MAX_PRINTS    = 40;

  localparam logic [vmalu_pkg::DATA_W-1:0] VAL_MIN = {1'b1, {(vmalu_pkg::DATA_W-1){1'b0}}};
  localparam logic [vmalu_pkg::DATA_W-1:0] VAL_MAX = ~VAL_MIN;
  localparam logic [vmalu_pkg::CMD_W-1:0]  CMD_UNUSED_TOP = '1;

  typedef struct {
    logic [vmalu_pkg::DATA_W-1:0] result;
    logic [vmalu_pkg::DATA_W-1:0] second_value;
    logic                         writes_result;
    logic                         branch_taken;
    logic                         negative_flag;
    logic                         zero_flag;
    logic                         div_error;
  } exec_result_t;

  logic clk;
  logic rst_n;

  vmalu_in_if  in_ch ();
  vmalu_out_if out_ch ();

  vm_alu_with_nz_flags_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic flag_n;
  logic flag_z;
  exec_result_t pending_results[$];

  int unsigned mismatches;
  int unsigned n_ops;
  int unsigned n_divs;
  int unsigned n_div_zero;
  int unsigned n_taken;
  int unsigned quiet_cycles;

  logic        no_idle;
  int unsigned hold_epoch;
  int unsigned hold_seen;
  int unsigned hold_left;

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic exec_result_t execute_op(logic [vmalu_pkg::CMD_W-1:0] code,
                                              logic [vmalu_pkg::DATA_W-1:0] a,
                                              logic [vmalu_pkg::DATA_W-1:0] b);
    exec_result_t                 r;
    logic                         take;
    logic                         sets_flags;
    logic                         shift_ok;
    logic [vmalu_pkg::DATA_W-1:0] flag_src;
    logic [vmalu_pkg::DATA_W-1:0] ma, mb, quo, rem;
    r = '{default: '0};
    take       = 1'b0;
    sets_flags = 1'b0;
    shift_ok   = (b < vmalu_pkg::DATA_W);
    case (code)
      vmalu_pkg::CMD_MOV: begin
        r.result = b;
        r.writes_result = 1'b1;
      end
      vmalu_pkg::CMD_ADD: begin
        r.result = a + b; r.writes_result = 1'b1; sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_SUB: begin
        r.result = a - b; r.writes_result = 1'b1; sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_MUL: begin
        r.result = a * b; r.writes_result = 1'b1; sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_DIV: begin
        if (b == '0) begin
          r.div_error = 1'b1;
        end else begin
          // magnitudes, then fix signs: truncation toward zero
          ma = a[vmalu_pkg::DATA_W-1] ? -a : a;
          mb = b[vmalu_pkg::DATA_W-1] ? -b : b;
          quo = ma / mb;
          rem = ma % mb;
          r.result       = (a[vmalu_pkg::DATA_W-1] ^ b[vmalu_pkg::DATA_W-1]) ? -quo : quo;
          r.second_value = a[vmalu_pkg::DATA_W-1] ? -rem : rem;
          r.writes_result = 1'b1;
          sets_flags = 1'b1;
        end
      end
      vmalu_pkg::CMD_SHL: begin
        r.result = shift_ok ? (a << b[vmalu_pkg::SHAMT_W-1:0]) : '0;
        r.writes_result = 1'b1;
        sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_SHR: begin
        r.result = shift_ok ? (a >> b[vmalu_pkg::SHAMT_W-1:0]) : '0;
        r.writes_result = 1'b1;
        sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_SAR: begin
        r.result = shift_ok ? $unsigned($signed(a) >>> b[vmalu_pkg::SHAMT_W-1:0])
                            : {vmalu_pkg::DATA_W{a[vmalu_pkg::DATA_W-1]}};
        r.writes_result = 1'b1;
        sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_AND: begin
        r.result = a & b; r.writes_result = 1'b1; sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_OR: begin
        r.result = a | b; r.writes_result = 1'b1; sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_XOR: begin
        r.result = a ^ b; r.writes_result = 1'b1; sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_LDL: begin
        r.result = {a[vmalu_pkg::DATA_W-1:vmalu_pkg::HALF_W], b[vmalu_pkg::HALF_W-1:0]};
        r.writes_result = 1'b1;
      end
      vmalu_pkg::CMD_LDH: begin
        r.result = {b[vmalu_pkg::HALF_W-1:0], a[vmalu_pkg::HALF_W-1:0]};
        r.writes_result = 1'b1;
      end
      vmalu_pkg::CMD_NOT: begin
        r.result = ~a; r.writes_result = 1'b1; sets_flags = 1'b1;
      end
      vmalu_pkg::CMD_CMP: sets_flags = 1'b1;
      vmalu_pkg::CMD_JMP: take = 1'b1;
      vmalu_pkg::CMD_JZ:  take = flag_z;
      vmalu_pkg::CMD_JNZ: take = !flag_z;
      vmalu_pkg::CMD_JN:  take = flag_n;
      vmalu_pkg::CMD_JNN: take = !flag_n;
      vmalu_pkg::CMD_JP:  take = !flag_z && !flag_n;
      vmalu_pkg::CMD_JNP: take = flag_z || flag_n;
      vmalu_pkg::CMD_SWAP: begin
        r.result = b;
        r.second_value = a;
        r.writes_result = 1'b1;
      end
      default: ;  // unassigned codes: no effect
    endcase
    if (sets_flags) begin
      flag_src = (code == vmalu_pkg::CMD_CMP) ? a - b : r.result;
      flag_n = flag_src[vmalu_pkg::DATA_W-1];
      flag_z = (flag_src == '0);
    end
    if (take) begin
      r.branch_taken = 1'b1;
      r.result = a;
    end
    r.negative_flag = flag_n;
    r.zero_flag     = flag_z;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_op(logic [vmalu_pkg::CMD_W-1:0] code, logic [vmalu_pkg::DATA_W-1:0] a,
                         logic [vmalu_pkg::DATA_W-1:0] b);
    exec_result_t r;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= code;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    r = execute_op(code, a, b);
    pending_results.push_back(r);
    n_ops++;
    if (code == vmalu_pkg::CMD_DIV) n_divs++;
    if (r.div_error) n_div_zero++;
    if (r.branch_taken) n_taken++;
  endtask

  function automatic logic [vmalu_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: case ($urandom_range(4))
           0:       return '0;
           1:       return 1;
           2:       return '1;
           3:       return VAL_MIN;
           default: return VAL_MAX;
         endcase
      1:       return $urandom_range(15);
      2:       return '0 - $urandom_range(16, 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [vmalu_pkg::DATA_W-1:0] pick_shift_count();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return vmalu_pkg::DATA_W + $urandom_range(8);
      2:       return '0 - $urandom_range(4, 1);
      default: return $urandom_range(vmalu_pkg::DATA_W - 1);
    endcase
  endfunction

  task automatic send_random_item();
    logic [vmalu_pkg::CMD_W-1:0]  code;
    logic [vmalu_pkg::DATA_W-1:0] b;
    if ($urandom_range(99) < 15) begin
      // compare followed by a conditional jump on the fresh flags
      send_op(vmalu_pkg::CMD_CMP, pick_value(), pick_value());
      send_op(vmalu_pkg::CMD_W'(vmalu_pkg::CMD_JZ +
                                $urandom_range(vmalu_pkg::CMD_JNP - vmalu_pkg::CMD_JZ)),
              $urandom(), $urandom());
    end else begin
      if ($urandom_range(99) < 8)
        code = vmalu_pkg::CMD_W'($urandom_range(CMD_UNUSED_TOP, vmalu_pkg::CMD_SWAP + 1));
      else
        code = vmalu_pkg::CMD_W'($urandom_range(vmalu_pkg::CMD_SWAP));
      case (code)
        vmalu_pkg::CMD_SHL, vmalu_pkg::CMD_SHR, vmalu_pkg::CMD_SAR: b = pick_shift_count();
        vmalu_pkg::CMD_DIV: b = ($urandom_range(11) == 0) ? '0 : pick_value();
        default: b = pick_value();
      endcase
      send_op(code, pick_value(), b);
    end
  endtask

  task automatic send_random_batch(int unsigned count);
    int unsigned target;
    target = n_ops + count;
    while (n_ops < target) send_random_item();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_each_operation();
    for (int c = vmalu_pkg::CMD_MOV; c <= vmalu_pkg::CMD_SWAP; c++)
      send_op(vmalu_pkg::CMD_W'(c), (c % 2) ? VAL_MIN + 1 : VAL_MAX, (c % 3) ? 32'd5 : '1);
  endtask

  task automatic test_special_cases();
    send_op(vmalu_pkg::CMD_SHL, 32'h1, vmalu_pkg::DATA_W);        // count too large
    send_op(vmalu_pkg::CMD_SAR, VAL_MIN, '0 - 32'd5);             // negative count, sign fill
    send_op(vmalu_pkg::CMD_SHR, VAL_MAX, '1);
    send_op(vmalu_pkg::CMD_DIV, 32'd17, '0);                      // zero divisor
    send_op(vmalu_pkg::CMD_DIV, VAL_MIN, '1);                     // wraps to most negative
    send_op(vmalu_pkg::CMD_DIV, '0 - 32'd7, 32'd2);               // truncation toward zero
    send_op(CMD_UNUSED_TOP, '1, '1);
    send_op(vmalu_pkg::CMD_CMP, 32'd9, 32'd9);
    send_op(vmalu_pkg::CMD_JZ, 32'h0000_0100, '0);
    send_op(vmalu_pkg::CMD_JNP, 32'h0000_0200, '0);
    send_op(vmalu_pkg::CMD_CMP, 32'd1, 32'd2);
    send_op(vmalu_pkg::CMD_JP, 32'h0000_0300, '0);
  endtask

  task automatic test_random_back_to_back();
    no_idle <= 1'b1;
    send_random_batch(400);
    no_idle <= 1'b0;
  endtask

  task automatic test_random_with_idling();
    send_random_batch(1500);
  endtask

  task automatic test_result_stall();
    hold_epoch <= hold_epoch + 1;
    send_random_batch(60);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready generation and checking
  // --------------------------------------------------------------------------
  initial begin
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_epoch != hold_seen) begin
        hold_seen = hold_epoch;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic report_mismatch(string what, logic [vmalu_pkg::DATA_W-1:0] got,
                                 logic [vmalu_pkg::DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_ch.result, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result !== want.result)
          report_mismatch("result", out_ch.result, want.result);
        if (out_ch.second_value !== want.second_value)
          report_mismatch("second_value", out_ch.second_value, want.second_value);
        if (out_ch.writes_result !== want.writes_result)
          report_mismatch("writes_result", vmalu_pkg::DATA_W'(out_ch.writes_result),
                          vmalu_pkg::DATA_W'(want.writes_result));
        if (out_ch.branch_taken !== want.branch_taken)
          report_mismatch("branch_taken", vmalu_pkg::DATA_W'(out_ch.branch_taken),
                          vmalu_pkg::DATA_W'(want.branch_taken));
        if (out_ch.negative_flag !== want.negative_flag)
          report_mismatch("negative_flag", vmalu_pkg::DATA_W'(out_ch.negative_flag),
                          vmalu_pkg::DATA_W'(want.negative_flag));
        if (out_ch.zero_flag !== want.zero_flag)
          report_mismatch("zero_flag", vmalu_pkg::DATA_W'(out_ch.zero_flag),
                          vmalu_pkg::DATA_W'(want.zero_flag));
        if (out_ch.div_error !== want.div_error)
          report_mismatch("div_error", vmalu_pkg::DATA_W'(out_ch.div_error),
                          vmalu_pkg::DATA_W'(want.div_error));
      end
    end
  end

  // no transaction on either side for too long: hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
          $display("FAIL vm_alu_with_nz_flags_unit");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    flag_n       = 1'b0;
    flag_z       = 1'b0;
    mismatches   = 0;
    n_ops        = 0;
    n_divs       = 0;
    n_div_zero   = 0;
    n_taken      = 0;
    quiet_cycles = 0;
    hold_epoch   = 0;
    rst_n           <= 1'b0;
    no_idle         <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= '0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_each_operation();
    test_special_cases();
    test_random_back_to_back();
    test_random_with_idling();
    test_result_stall();
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operations: %0d divides (%0d by zero), %0d jumps taken,",
             n_ops, n_divs, n_div_zero, n_taken);
    $display("with random idling on both channels and a %0d-cycle result stall.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASS vm_alu_with_nz_flags_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL vm_alu_with_nz_flags_unit");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/vmalu_pkg.sv
rtl/vmalu_if.sv
rtl/vmalu_ctrl.sv
rtl/vmalu_dp.sv
rtl/vm_alu_with_nz_flags_unit.sv
rtl/vmalu_checker.sv
dv/vm_alu_with_nz_flags_unit_tb.sv
